FILE: rtl/core/bmhpq_pkg.sv
// Shared constants and codes for the binary min-heap priority queue.
// Used by the controller, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps

package bmhpq_pkg;

    // Entry count and capacity width, fixed by the register and result fields.
    localparam int CNT_W = 7;
    // Heap positions and child indexes: a count below 128 gives children below 256.
    localparam int POS_W = CNT_W + 1;
    // Largest entry count the count field can express.
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

endpackage

FILE: rtl/core/bmhpq_cmp.sv
// Shared signed priority comparator of the heap controller.
// Depends on nothing; instantiated once by the top level.
`timescale 1ns / 1ps

module bmhpq_cmp #(
    parameter int PRIORITY_BITS = 32
) (
    input  logic [PRIORITY_BITS-1:0] i_a,
    input  logic [PRIORITY_BITS-1:0] i_b,
    output logic                     o_lt
);

    assign o_lt = $signed(i_a) < $signed(i_b);

endmodule

FILE: rtl/core/bmhpq_store.sv
// Heap entry memory: one write port, two read ports with registered read data.
// Each word holds a value above its priority. No package dependencies.
`timescale 1ns / 1ps

module bmhpq_store #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds between reads so later compares can reuse it.
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: rtl/core/bmhpq_ctrl.sv
// Heap sequencer: entry count, sift-up and sift-down stepping, result registers.
// Uses bmhpq_pkg; drives the entry memory and the shared comparator.
`timescale 1ns / 1ps

module bmhpq_ctrl #(
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 32,
    parameter int ADDR_W        = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic                                  i_mode,
    input  logic [VALUE_BITS-1:0]                 i_item_value,
    input  logic [PRIORITY_BITS-1:0]              i_item_priority,
    input  logic [bmhpq_pkg::CNT_W-1:0]           i_cap,
    output logic                                  o_mem_we,
    output logic [ADDR_W-1:0]                     o_mem_waddr,
    output logic [VALUE_BITS+PRIORITY_BITS-1:0]   o_mem_wdata,
    output logic                                  o_mem_re,
    output logic [ADDR_W-1:0]                     o_mem_raddr_a,
    output logic [ADDR_W-1:0]                     o_mem_raddr_b,
    input  logic [VALUE_BITS+PRIORITY_BITS-1:0]   i_mem_rdata_a,
    input  logic [VALUE_BITS+PRIORITY_BITS-1:0]   i_mem_rdata_b,
    output logic [PRIORITY_BITS-1:0]              o_cmp_a,
    output logic [PRIORITY_BITS-1:0]              o_cmp_b,
    input  logic                                  i_cmp_lt,
    output logic                                  o_done,
    output logic [1:0]                            o_status,
    output logic [VALUE_BITS-1:0]                 o_out_value,
    output logic [bmhpq_pkg::CNT_W-1:0]           o_entry_total,
    output logic                                  o_heap_empty,
    output logic                                  o_heap_full
);

    localparam int CW = bmhpq_pkg::CNT_W;
    localparam int PW = bmhpq_pkg::POS_W;
    localparam int DW = VALUE_BITS + PRIORITY_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_FIN,
        S_EX,
        S_DN_L,
        S_DN_R
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [PW-1:0]            r_pos, n_pos;
    logic [PW-1:0]            r_par, n_par;
    logic [VALUE_BITS-1:0]    r_item_val, n_item_val;
    logic [PRIORITY_BITS-1:0] r_item_pri, n_item_pri;
    logic [VALUE_BITS-1:0]    r_res_val, n_res_val;
    logic                     r_sel_l, n_sel_l;
    logic                     r_done, n_done;
    logic [1:0]               r_status, n_status;
    logic [VALUE_BITS-1:0]    r_out_value, n_out_value;
    logic [CW-1:0]            r_total, n_total;
    logic                     r_empty, n_empty;
    logic                     r_full, n_full;

    logic                     fin;
    logic [VALUE_BITS-1:0]    rd_a_val;
    logic [PRIORITY_BITS-1:0] rd_a_pri;
    logic [PRIORITY_BITS-1:0] rd_b_pri;
    logic [PW-1:0]            lchild;
    logic [PW-1:0]            rchild;
    logic [PW-1:0]            cnt_ext;
    logic [PW-1:0]            child;
    logic [PW-1:0]            up_next;
    logic                     take_r;

    assign rd_a_val = i_mem_rdata_a[DW-1:PRIORITY_BITS];
    assign rd_a_pri = i_mem_rdata_a[PRIORITY_BITS-1:0];
    assign rd_b_pri = i_mem_rdata_b[PRIORITY_BITS-1:0];
    assign lchild   = (r_pos << 1) + PW'(1);
    assign rchild   = (r_pos << 1) + PW'(2);
    assign cnt_ext  = {1'b0, r_count};
    assign up_next  = (r_par - PW'(1)) >> 1;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_par       = r_par;
        n_item_val  = r_item_val;
        n_item_pri  = r_item_pri;
        n_res_val   = r_res_val;
        n_sel_l     = r_sel_l;
        n_done      = 1'b0;
        n_status    = r_status;
        n_out_value = r_out_value;
        n_total     = r_total;
        n_empty     = r_empty;
        n_full      = r_full;
        fin         = 1'b0;
        take_r      = 1'b0;
        child       = lchild;

        o_mem_we      = 1'b0;
        o_mem_waddr   = ADDR_W'(r_pos);
        o_mem_wdata   = {r_item_val, r_item_pri};
        o_mem_re      = 1'b0;
        o_mem_raddr_a = ADDR_W'(lchild);
        o_mem_raddr_b = ADDR_W'(rchild);
        o_cmp_a       = r_item_pri;
        o_cmp_b       = rd_a_pri;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item_val = i_item_value;
                    n_item_pri = i_item_priority;
                    n_res_val  = '0;
                    if (i_mode == bmhpq_pkg::MODE_INSERT) begin
                        if (r_count >= i_cap) begin
                            fin         = 1'b1;
                            n_status    = bmhpq_pkg::STAT_FULL;
                            n_out_value = '0;
                        end else begin
                            n_count = r_count + CW'(1);
                            if (r_count == '0) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = '0;
                                o_mem_wdata = {i_item_value, i_item_priority};
                                fin         = 1'b1;
                                n_status    = bmhpq_pkg::STAT_OK;
                                n_out_value = '0;
                            end else begin
                                // The new entry starts as a hole at the end of the heap.
                                n_pos         = cnt_ext;
                                n_par         = (cnt_ext - PW'(1)) >> 1;
                                o_mem_re      = 1'b1;
                                o_mem_raddr_a = ADDR_W'((cnt_ext - PW'(1)) >> 1);
                                n_state       = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            fin         = 1'b1;
                            n_status    = bmhpq_pkg::STAT_EMPTY;
                            n_out_value = '0;
                        end else begin
                            o_mem_re      = 1'b1;
                            o_mem_raddr_a = '0;
                            o_mem_raddr_b = ADDR_W'(r_count - CW'(1));
                            n_count       = r_count - CW'(1);
                            n_state       = S_EX;
                        end
                    end
                end
            end

            S_UP: begin
                o_cmp_a = r_item_pri;
                o_cmp_b = rd_a_pri;
                if (i_cmp_lt) begin
                    // Parent is strictly greater: it moves down into the hole.
                    o_mem_we    = 1'b1;
                    o_mem_wdata = i_mem_rdata_a;
                    n_pos       = r_par;
                    if (r_par == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_par         = up_next;
                        o_mem_re      = 1'b1;
                        o_mem_raddr_a = ADDR_W'(up_next);
                    end
                end else begin
                    o_mem_we    = 1'b1;
                    fin         = 1'b1;
                    n_status    = bmhpq_pkg::STAT_OK;
                    n_out_value = r_res_val;
                end
            end

            S_FIN: begin
                o_mem_we    = 1'b1;
                fin         = 1'b1;
                n_status    = bmhpq_pkg::STAT_OK;
                n_out_value = r_res_val;
            end

            S_EX: begin
                n_res_val  = rd_a_val;
                n_item_val = i_mem_rdata_b[DW-1:PRIORITY_BITS];
                n_item_pri = rd_b_pri;
                n_pos      = '0;
                if (r_count == '0) begin
                    fin         = 1'b1;
                    n_status    = bmhpq_pkg::STAT_OK;
                    n_out_value = rd_a_val;
                end else begin
                    o_mem_re      = 1'b1;
                    o_mem_raddr_a = ADDR_W'(1);
                    o_mem_raddr_b = ADDR_W'(2);
                    n_state       = S_DN_L;
                end
            end

            S_DN_L: begin
                o_cmp_a = rd_a_pri;
                o_cmp_b = r_item_pri;
                n_sel_l = (lchild < cnt_ext) && i_cmp_lt;
                n_state = S_DN_R;
            end

            S_DN_R: begin
                o_cmp_a = rd_b_pri;
                o_cmp_b = r_sel_l ? rd_a_pri : r_item_pri;
                take_r  = (rchild < cnt_ext) && i_cmp_lt;
                if (take_r || r_sel_l) begin
                    child         = take_r ? rchild : lchild;
                    o_mem_we      = 1'b1;
                    o_mem_wdata   = take_r ? i_mem_rdata_b : i_mem_rdata_a;
                    n_pos         = child;
                    o_mem_re      = 1'b1;
                    o_mem_raddr_a = ADDR_W'((child << 1) + PW'(1));
                    o_mem_raddr_b = ADDR_W'((child << 1) + PW'(2));
                    n_state       = S_DN_L;
                end else begin
                    o_mem_we    = 1'b1;
                    fin         = 1'b1;
                    n_status    = bmhpq_pkg::STAT_OK;
                    n_out_value = r_res_val;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_done  = 1'b1;
            n_state = S_IDLE;
            n_total = n_count;
            n_empty = (n_count == '0);
            n_full  = (n_count >= i_cap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_pos       <= n_pos;
        r_par       <= n_par;
        r_item_val  <= n_item_val;
        r_item_pri  <= n_item_pri;
        r_res_val   <= n_res_val;
        r_sel_l     <= n_sel_l;
        r_status    <= n_status;
        r_out_value <= n_out_value;
        r_total     <= n_total;
        r_empty     <= n_empty;
        r_full      <= n_full;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_out_value   = r_out_value;
    assign o_entry_total = r_total;
    assign o_heap_empty  = r_empty;
    assign o_heap_full   = r_full;

endmodule

FILE: rtl/core/binary_min_heap_priority_queue.sv
// One transaction at a time: the next start is taken in the cycle the done strobe shows.
// The heap stepping is set by the single memory write port and the one shared comparator.
// Synchronous reset empties the heap and sets the capacity to 64; memory is not cleared.
`timescale 1ns / 1ps

module binary_min_heap_priority_queue #(
    parameter int HEAP_DEPTH    = 64,
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic signed [VALUE_BITS-1:0]    i_item_value,
    input  logic signed [PRIORITY_BITS-1:0] i_item_priority,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic signed [VALUE_BITS-1:0]    o_out_value,
    output logic [bmhpq_pkg::CNT_W-1:0]     o_entry_total,
    output logic                            o_heap_empty,
    output logic                            o_heap_full,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bmhpq_pkg::CNT_W-1:0]     i_capacity_limit
);

    localparam int CW       = bmhpq_pkg::CNT_W;
    localparam int ADDR_W   = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int DW       = VALUE_BITS + PRIORITY_BITS;
    localparam int CapCeil  = (HEAP_DEPTH > bmhpq_pkg::CNT_MAX) ? bmhpq_pkg::CNT_MAX
                                                               : HEAP_DEPTH;

    logic [CW-1:0]            r_cap;
    logic [CW-1:0]            cap_eff;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [DW-1:0]            mem_wdata;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr_a;
    logic [ADDR_W-1:0]        mem_raddr_b;
    logic [DW-1:0]            mem_rdata_a;
    logic [DW-1:0]            mem_rdata_b;
    logic [PRIORITY_BITS-1:0] cmp_a;
    logic [PRIORITY_BITS-1:0] cmp_b;
    logic                     cmp_lt;
    logic [VALUE_BITS-1:0]    out_value;

    assign o_cfg_ready = ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bmhpq_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_capacity_limit;
        end
    end

    // A capacity beyond the built depth saturates to it.
    assign cap_eff = (r_cap > CW'(CapCeil)) ? CW'(CapCeil) : r_cap;

    bmhpq_ctrl #(
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_mode          (i_mode),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .i_cap           (cap_eff),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr_a   (mem_raddr_a),
        .o_mem_raddr_b   (mem_raddr_b),
        .i_mem_rdata_a   (mem_rdata_a),
        .i_mem_rdata_b   (mem_rdata_b),
        .o_cmp_a         (cmp_a),
        .o_cmp_b         (cmp_b),
        .i_cmp_lt        (cmp_lt),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_out_value     (out_value),
        .o_entry_total   (o_entry_total),
        .o_heap_empty    (o_heap_empty),
        .o_heap_full     (o_heap_full)
    );

    assign o_out_value = out_value;

    bmhpq_store #(
        .DEPTH  (HEAP_DEPTH),
        .DATA_W (DW),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    bmhpq_cmp #(
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (cmp_lt)
    );

endmodule

FILE: rtl/core/bmhpq_chk.sv
// Port-level checker for the heap priority queue, bound to the top level.
// Uses bmhpq_pkg for the status codes.
`timescale 1ns / 1ps

module bmhpq_chk #(
    parameter int VALUE_BITS = 32
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_done,
    input logic [1:0]                        o_status,
    input logic [VALUE_BITS-1:0]             o_out_value,
    input logic [bmhpq_pkg::CNT_W-1:0]       o_entry_total,
    input logic                              o_heap_empty
);

    // A result is only presented once the transaction has left the busy phase.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Busy is only entered from an accepted start.
    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_heap_empty == (o_entry_total == '0)))
        else $error("empty flag disagrees with entry total");

    a_reject_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != bmhpq_pkg::STAT_OK)) |-> (o_out_value == '0))
        else $error("nonzero value on a rejected transaction");

    a_empty_extract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == bmhpq_pkg::STAT_EMPTY)) |-> (o_entry_total == '0))
        else $error("empty status with entries held");

endmodule

bind binary_min_heap_priority_queue bmhpq_chk #(
    .VALUE_BITS (VALUE_BITS)
) u_bmhpq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_out_value   (o_out_value),
    .o_entry_total (o_entry_total),
    .o_heap_empty  (o_heap_empty)
);
